FILE: rtl/core/wtlc_pkg.sv
package wtlc_pkg;

  // Cache geometry: lines of four 32-bit words.
  localparam int LINES  = 64;
  localparam int LINE_W = $clog2(LINES);
  localparam int WORD_AW = LINE_W + 2;
  localparam int TAG_W  = 28;
  localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(LINES - 1);

  // Request commands.
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_FILL  = 2'd3
  } cmd_t;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_READ       = 3'd0,
    KIND_FILLREQ    = 3'd1,
    KIND_MEMWRITE   = 3'd2,
    KIND_FLUSHED    = 3'd3,
    KIND_MISALIGNED = 3'd4,
    KIND_BUSY       = 3'd5
  } kind_t;

  // Operation waiting for a line fill.
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

endpackage

FILE: rtl/core/wtlc_ram.sv
module wtlc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/write_through_line_cache.sv
// Fully associative write-through cache of 16-byte lines with FIFO replacement.
// Requests enter on the s_ channel: s_tuser carries the command (read, write,
// flush, fill word) and s_tdata the word address and write or fill data.
// Results leave on the m_ channel: m_tuser carries the result kind and m_tdata
// the address and data. A miss returns a line fill request; the memory side
// then sends four fill words as fill requests, and the fourth one completes
// the waiting read or write. Writes are passed through to memory.
// The block takes one request at a time. A lookup walks the tag memory one
// line per cycle through a single tag comparator, from line 0 upwards until a
// hit or the last line; a miss walks every line.
// A new request is accepted while the previous result still waits in the
// output register; the block stalls in its result step only if that register
// is still full when the next result is ready.
// Reset clears all valid bits, the allocation pointer and any waiting fill;
// no clearing pass is needed.
module write_through_line_cache
  import wtlc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // addr [31:0], wdata [63:32]
  input  logic [1:0]  s_tuser,   // cmd [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // out_addr [31:0], out_data [63:32]
  output logic [2:0]  m_tuser    // kind [2:0]
);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_DECODE   = 7'b0000010,
    ST_SCAN     = 7'b0000100,
    ST_HIT      = 7'b0001000,
    ST_FILL_END = 7'b0010000,
    ST_RDWAIT   = 7'b0100000,
    ST_RESULT   = 7'b1000000
  } state_t;

  state_t              state;
  cmd_t                cmd_r;
  logic [31:0]         addr_r;
  logic [31:0]         wdata_r;
  logic [LINES-1:0]    valid;
  logic [LINE_W-1:0]   alloc_slot;
  logic [LINE_W-1:0]   cmp_idx;
  logic [LINE_W-1:0]   line_idx;
  op_t                 pending_op;
  logic [31:0]         pending_addr;
  logic [31:0]         pending_word;
  logic [1:0]          fill_count;
  kind_t               res_kind;
  logic [31:0]         res_addr;
  logic [31:0]         res_data;

  logic                tag_we;
  logic [LINE_W-1:0]   tag_raddr;
  logic [TAG_W-1:0]    tag_rdata;
  logic                word_we;
  logic [WORD_AW-1:0]  word_waddr;
  logic [31:0]         word_wdata;
  logic [WORD_AW-1:0]  word_raddr;
  logic [31:0]         word_rdata;
  logic                out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Tag store: written when a fill completes, walked during lookup.
  assign tag_we    = (state == ST_DECODE) && (cmd_r == CMD_FILL) &&
                     (pending_op != OP_NONE) && (fill_count == 2'd3);
  assign tag_raddr = (state == ST_SCAN) ? cmp_idx + LINE_W'(1) : '0;

  wtlc_ram #(
    .WIDTH (TAG_W),
    .DEPTH (LINES)
  ) u_tags (
    .clk   (clk),
    .we    (tag_we),
    .waddr (alloc_slot),
    .wdata (pending_addr[31:4]),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  // Word store port selection.
  always_comb begin
    word_we    = 1'b0;
    word_waddr = {line_idx, pending_addr[3:2]};
    word_wdata = pending_word;
    word_raddr = {line_idx, pending_addr[3:2]};
    case (state)
      ST_DECODE: begin
        word_we    = (cmd_r == CMD_FILL) && (pending_op != OP_NONE);
        word_waddr = {alloc_slot, fill_count};
        word_wdata = wdata_r;
      end
      ST_HIT: begin
        word_we    = (cmd_r == CMD_WRITE);
        word_waddr = {line_idx, addr_r[3:2]};
        word_wdata = wdata_r;
        word_raddr = {line_idx, addr_r[3:2]};
      end
      ST_FILL_END: begin
        word_we = (pending_op == OP_WRITE);
      end
      default: begin
        word_we = 1'b0;
      end
    endcase
  end

  wtlc_ram #(
    .WIDTH (32),
    .DEPTH (4 * LINES)
  ) u_words (
    .clk   (clk),
    .we    (word_we),
    .waddr (word_waddr),
    .wdata (word_wdata),
    .raddr (word_raddr),
    .rdata (word_rdata)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      valid      <= '0;
      alloc_slot <= '0;
      pending_op <= OP_NONE;
      fill_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      // In the result step the output register is reloaded below instead.
      if (m_tvalid && m_tready && (state != ST_RESULT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd_r   <= cmd_t'(s_tuser);
            addr_r  <= s_tdata[31:0];
            wdata_r <= s_tdata[63:32];
            state   <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          res_addr <= addr_r;
          res_data <= '0;
          if (cmd_r == CMD_FILL) begin
            if (pending_op == OP_NONE) begin
              state <= ST_IDLE;
            end else if (fill_count != 2'd3) begin
              fill_count <= fill_count + 2'd1;
              state      <= ST_IDLE;
            end else begin
              fill_count        <= '0;
              valid[alloc_slot] <= 1'b1;
              line_idx          <= alloc_slot;
              alloc_slot        <= (alloc_slot == LAST_LINE) ? '0 : alloc_slot + LINE_W'(1);
              state             <= ST_FILL_END;
            end
          end else if (pending_op != OP_NONE) begin
            res_kind <= KIND_BUSY;
            state    <= ST_RESULT;
          end else if (cmd_r == CMD_FLUSH) begin
            valid      <= '0;
            alloc_slot <= '0;
            res_kind   <= KIND_FLUSHED;
            res_addr   <= '0;
            state      <= ST_RESULT;
          end else if (addr_r[1:0] != 2'b00) begin
            res_kind <= KIND_MISALIGNED;
            state    <= ST_RESULT;
          end else begin
            cmp_idx <= '0;
            state   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // One tag compared per cycle; the read for the next line is in flight.
          if (valid[cmp_idx] && (tag_rdata == addr_r[31:4])) begin
            line_idx <= cmp_idx;
            state    <= ST_HIT;
          end else if (cmp_idx == LAST_LINE) begin
            valid[alloc_slot] <= 1'b0;
            pending_op        <= (cmd_r == CMD_WRITE) ? OP_WRITE : OP_READ;
            pending_addr      <= addr_r;
            pending_word      <= wdata_r;
            fill_count        <= '0;
            res_kind          <= KIND_FILLREQ;
            res_addr          <= {addr_r[31:4], 4'b0000};
            state             <= ST_RESULT;
          end else begin
            cmp_idx <= cmp_idx + LINE_W'(1);
          end
        end
        ST_HIT: begin
          if (cmd_r == CMD_WRITE) begin
            res_kind <= KIND_MEMWRITE;
            res_data <= wdata_r;
            state    <= ST_RESULT;
          end else begin
            res_kind <= KIND_READ;
            state    <= ST_RDWAIT;
          end
        end
        ST_FILL_END: begin
          // The line is complete; finish the waiting read or write.
          pending_op <= OP_NONE;
          res_addr   <= pending_addr;
          if (pending_op == OP_WRITE) begin
            res_kind <= KIND_MEMWRITE;
            res_data <= pending_word;
            state    <= ST_RESULT;
          end else begin
            res_kind <= KIND_READ;
            state    <= ST_RDWAIT;
          end
        end
        ST_RDWAIT: begin
          res_data <= word_rdata;
          state    <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_kind;
            m_tdata  <= {res_data, res_addr};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/sv/wtlc_result_checker.sv
module wtlc_result_checker
  import wtlc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,   // addr [31:0], wdata [63:32]
  input  logic [1:0]  s_tuser,   // cmd [1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,   // out_addr [31:0], out_data [63:32]
  input  logic [2:0]  m_tuser,   // kind [2:0]
  output int          fail_count,
  output int          outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] addr;
    logic [31:0] data;
  } cache_result_t;

  // Shadow copy of the cache contents and of the miss in progress.
  logic [TAG_W-1:0]  tag_mem  [LINES];
  logic              line_ok  [LINES];
  logic [31:0]       word_mem [LINES*4];
  logic [LINE_W-1:0] claim_slot;
  op_t               wait_op;
  logic [31:0]       wait_addr;
  logic [31:0]       wait_data;
  logic [1:0]        fill_idx;

  cache_result_t expected_results [$];
  int            mismatches = 0;

  function automatic void queue_result(kind_t k, logic [31:0] a, logic [31:0] d);
    cache_result_t r;
    r.kind = k;
    r.addr = a;
    r.data = d;
    expected_results.push_back(r);
  endfunction

  // Works out what one accepted request does to the cache and what it returns.
  task automatic cache_request(input cmd_t c, input logic [31:0] a, input logic [31:0] d);
    int         hit;
    logic [1:0] w;
    hit = -1;
    if (c == CMD_FILL) begin
      // A fill word with no miss waiting is dropped silently.
      if (wait_op == OP_NONE) return;
      word_mem[{claim_slot, fill_idx}] = d;
      if (fill_idx != 2'd3) begin
        fill_idx = fill_idx + 2'd1;
        return;
      end
      fill_idx = '0;
      tag_mem[claim_slot] = wait_addr[31:4];
      line_ok[claim_slot] = 1'b1;
      w = wait_addr[3:2];
      if (wait_op == OP_WRITE) begin
        word_mem[{claim_slot, w}] = wait_data;
        queue_result(KIND_MEMWRITE, wait_addr, wait_data);
      end else begin
        queue_result(KIND_READ, wait_addr, word_mem[{claim_slot, w}]);
      end
      claim_slot = (claim_slot == LAST_LINE) ? '0 : claim_slot + 1'b1;
      wait_op = OP_NONE;
      return;
    end
    // Anything but a fill word is turned away while a miss is open,
    // even when its address is misaligned.
    if (wait_op != OP_NONE) begin
      queue_result(KIND_BUSY, a, '0);
      return;
    end
    if (c == CMD_FLUSH) begin
      for (int i = 0; i < LINES; i++) line_ok[i] = 1'b0;
      claim_slot = '0;
      queue_result(KIND_FLUSHED, '0, '0);
      return;
    end
    if (a[1:0] != 2'b00) begin
      queue_result(KIND_MISALIGNED, a, '0);
      return;
    end
    for (int i = 0; i < LINES; i++) begin
      if (line_ok[i] && tag_mem[i] == a[31:4]) begin
        hit = i;
        break;
      end
    end
    w = a[3:2];
    if (hit < 0) begin
      // Miss: the claimed line is dropped at once and memory is asked for the line.
      line_ok[claim_slot] = 1'b0;
      wait_op   = (c == CMD_WRITE) ? OP_WRITE : OP_READ;
      wait_addr = a;
      wait_data = d;
      fill_idx  = '0;
      queue_result(KIND_FILLREQ, {a[31:4], 4'b0000}, '0);
    end else if (c == CMD_WRITE) begin
      word_mem[hit*4 + w] = d;
      queue_result(KIND_MEMWRITE, a, d);
    end else begin
      queue_result(KIND_READ, a, word_mem[hit*4 + w]);
    end
  endtask

  // Results are compared before the request of the same edge is modelled; a request
  // can never produce its result on the edge that accepts it.
  always @(posedge clk) begin
    cache_result_t want;
    if (rst) begin
      for (int i = 0; i < LINES; i++) line_ok[i] = 1'b0;
      claim_slot = '0;
      wait_op    = OP_NONE;
      wait_addr  = '0;
      wait_data  = '0;
      fill_idx   = '0;
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d, out_addr %h, out_data %h",
                 m_tuser, m_tdata[31:0], m_tdata[63:32]);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (m_tuser !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, m_tuser);
            mismatches++;
          end
          if (m_tdata[31:0] !== want.addr) begin
            $error("out_addr: expected %h, got %h", want.addr, m_tdata[31:0]);
            mismatches++;
          end
          if (m_tdata[63:32] !== want.data) begin
            $error("out_data: expected %h, got %h", want.data, m_tdata[63:32]);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        cache_request(cmd_t'(s_tuser), s_tdata[31:0], s_tdata[63:32]);
      end
    end
    fail_count  <= mismatches;
    outstanding <= expected_results.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import wtlc_pkg::*;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;        // addr [31:0], wdata [63:32]
  logic [1:0]  s_tuser  = CMD_READ;  // cmd [1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;              // out_addr [31:0], out_data [63:32]
  logic [2:0]  m_tuser;              // kind [2:0]

  int          fail_count;
  int          outstanding;

  // Stimulus bookkeeping: results owed by the block and results taken so far.
  int          results_due   = 0;
  int          results_taken = 0;
  kind_t       last_kind     = KIND_READ;
  int          n_items       = 0;
  int          stall_left    = 0;
  bit          calm          = 1'b0;
  logic [20:0] region_a;

  always #1 clk = ~clk;

  write_through_line_cache i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  wtlc_result_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Idle stretches are mostly short, with the odd long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  // Addresses mostly fall in two regions of 80 lines, more than the cache holds,
  // so that hits, misses and evictions all occur.
  function automatic logic [31:0] pick_addr();
    logic [20:0] region;
    region = ($urandom_range(0, 9) < 7) ? region_a : '1;
    return {region, 7'($urandom_range(0, 79)), 2'($urandom_range(0, 3)), 2'b00};
  endfunction

  // The result side stalls at random unless a calm stretch is running.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      m_tready   <= 1'b0;
      stall_left <= idle_len() - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_taken <= results_taken + 1;
      last_kind     <= kind_t'(m_tuser);
    end
  end

  // Presents one request after a random gap and returns on the edge that takes it.
  // Every request except a fill word produces one result.
  task automatic send_req(input cmd_t c, input logic [31:0] a, input logic [31:0] d);
    int gap;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c;
    s_tdata  <= {d, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (c != CMD_FILL) begin
      results_due++;
      n_items++;
    end
  endtask

  // Stops requesting and waits until every owed result has been taken.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_taken != results_due);
  endtask

  // Answers an open miss with four fill words, with rejected requests mixed in.
  task automatic fill_line(input int busy_pct);
    for (int k = 0; k < 4; k++) begin
      if ($urandom_range(0, 99) < busy_pct) begin
        send_req(cmd_t'($urandom_range(0, 2)), $urandom, $urandom);
      end
      send_req(CMD_FILL, $urandom, $urandom);
      n_items++;
      if (k == 3) results_due++;
    end
  endtask

  // A read or write; a miss is followed by its line fill.
  task automatic access(input cmd_t c, input logic [31:0] a, input logic [31:0] d,
                        input int busy_pct);
    send_req(c, a, d);
    settle();
    if (last_kind == KIND_FILLREQ) fill_line(busy_pct);
  endtask

  initial begin
    logic [31:0] a;
    int          r;
    region_a = 21'($urandom);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: miss into an empty cache, hits, write hit, misalignment.
    access(CMD_READ, 32'h0000_0000, 32'h0000_0000, 0);
    access(CMD_READ, 32'h0000_000C, 32'h0000_0000, 0);
    access(CMD_WRITE, 32'h0000_0008, 32'hFFFF_FFFF, 0);
    access(CMD_READ, 32'h0000_0008, 32'h0000_0000, 0);
    send_req(CMD_READ, 32'h0000_0001, 32'h0000_0000);
    send_req(CMD_WRITE, 32'h0000_0002, 32'hFFFF_FFFF);
    send_req(CMD_READ, 32'hFFFF_FFFF, 32'h0000_0000);
    // A fill word while nothing is waiting.
    send_req(CMD_FILL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Write miss at the top of the address space; everything is rejected meanwhile,
    // including a misaligned read.
    send_req(CMD_WRITE, 32'hFFFF_FFFC, 32'h0000_0000);
    settle();
    if (last_kind == KIND_FILLREQ) begin
      send_req(CMD_READ, 32'h0000_0003, 32'h0000_0000);
      send_req(CMD_FLUSH, 32'h0000_0000, 32'h0000_0000);
      send_req(CMD_WRITE, 32'h0000_0004, 32'h1234_5678);
      fill_line(0);
    end
    access(CMD_READ, 32'hFFFF_FFFC, 32'h0000_0000, 0);
    send_req(CMD_FLUSH, 32'h0000_0000, 32'h0000_0000);
    access(CMD_READ, 32'h0000_0000, 32'h0000_0000, 0);
    settle();

    // Random part: mostly reads and writes with their fills, the rest noise.
    while (n_items < 1225) begin
      if ($urandom_range(0, 49) == 0) calm <= ~calm;
      r = $urandom_range(0, 99);
      if (r < 80) begin
        access(cmd_t'($urandom_range(0, 1)), pick_addr(), $urandom, 10);
      end else if (r < 87) begin
        a = $urandom;
        if (a[1:0] == 2'b00) a[1:0] = 2'($urandom_range(1, 3));
        send_req(cmd_t'($urandom_range(0, 1)), a, $urandom);
      end else if (r < 90) begin
        send_req(CMD_FLUSH, $urandom, $urandom);
      end else if (r < 96) begin
        send_req(CMD_FILL, $urandom, $urandom);
      end else begin
        a = $urandom;
        a[1:0] = 2'b00;
        access(cmd_t'($urandom_range(0, 1)), a, $urandom, 10);
      end
    end

    settle();
    while (outstanding != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop for a hung run.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/wtlc_pkg.sv
rtl/core/wtlc_ram.sv
rtl/core/write_through_line_cache.sv
tb/sv/wtlc_result_checker.sv
tb/sv/tb_top.sv
